/* src/lsd_pkg.sv */
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared constants, types and the window snapshot for the shore distance pass.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // Distance cap; the look-ahead window holds one more position than this.
    localparam int MAX_LEVEL = 5;
    localparam int WIN       = MAX_LEVEL + 1;

    // Fixed field widths
    localparam int HEIGHT_W = 16;
    localparam int PRIOR_W  = 3;
    localparam int SHORE_W  = 3;

    // Derived widths
    localparam int FILL_W = $clog2(WIN + 1);   // 0..WIN
    localparam int IDX_W  = $clog2(WIN);       // 0..WIN-1
    localparam int DIST_W = $clog2(WIN + 1);   // distances 0..WIN
    localparam int CMP_W  = (DIST_W > PRIOR_W) ? DIST_W : PRIOR_W;

    // APB
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_IDX_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        ST_STREAM = 2'b01,
        ST_FLUSH  = 2'b10
    } state_t;

    // Snapshot of the pending positions handed to the emit logic
    typedef struct packed {
        logic [WIN-1:0]              land;
        logic [WIN-1:0][PRIOR_W-1:0] prior;
        logic [FILL_W-1:0]           fill;
        logic [DIST_W-1:0]           back;
    } window_t;

    typedef struct packed {
        logic [SHORE_W-1:0] shore;
        logic [DIST_W-1:0]  level;
    } emit_t;

endpackage

/* src/lsd_in_if.sv */
// ----------------------------------------------------------------------------
// lsd_in_if
// Sample channel: one height sample with its prior distance per transfer.
// ----------------------------------------------------------------------------
interface lsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [lsd_pkg::HEIGHT_W-1:0]  height_sample;
    logic [lsd_pkg::PRIOR_W-1:0]   prior_distance;
    logic                          last_in_line;

    modport source (output valid, output height_sample, output prior_distance,
                    output last_in_line, input ready);
    modport sink   (input valid, input height_sample, input prior_distance,
                    input last_in_line, output ready);
endinterface

/* src/lsd_out_if.sv */
// ----------------------------------------------------------------------------
// lsd_out_if
// Result channel: one updated distance per transfer, in line order.
// ----------------------------------------------------------------------------
interface lsd_out_if;
    logic                         valid;
    logic                         ready;
    logic [lsd_pkg::SHORE_W-1:0]  shore_distance;
    logic                         line_done;

    modport source (output valid, output shore_distance, output line_done,
                    input ready);
    modport sink   (input valid, input shore_distance, input line_done,
                    output ready);
endinterface

/* src/lsd_emit.sv */
// ----------------------------------------------------------------------------
// lsd_emit
// Distance of the oldest pending position: min of prior, back and forward.
// ----------------------------------------------------------------------------
module lsd_emit (
    input  lsd_pkg::window_t win,
    output lsd_pkg::emit_t   res
);

    logic [lsd_pkg::FILL_W-1:0] fwd;
    logic [lsd_pkg::DIST_W-1:0] level;
    logic [lsd_pkg::CMP_W-1:0]  nearest;

    // Forward distance: nearest later land inside the window, else the
    // number of pending positions (one past line end, or the window depth).
    always_comb
    begin
        fwd = win.fill;
        for (int j = lsd_pkg::WIN - 1; j >= 1; j--)
        begin
            if (win.land[j] && (lsd_pkg::FILL_W'(j) < win.fill))
            begin
                fwd = lsd_pkg::FILL_W'(j);
            end
        end
    end

    always_comb
    begin
        if (win.land[0])
        begin
            level = '0;
        end
        else if (win.back >= lsd_pkg::DIST_W'(lsd_pkg::MAX_LEVEL))
        begin
            level = lsd_pkg::DIST_W'(lsd_pkg::MAX_LEVEL);
        end
        else
        begin
            level = win.back + 1'b1;
        end
    end

    always_comb
    begin
        nearest = lsd_pkg::CMP_W'(win.prior[0]);
        if (lsd_pkg::CMP_W'(level) < nearest)
        begin
            nearest = lsd_pkg::CMP_W'(level);
        end
        if (lsd_pkg::CMP_W'(fwd) < nearest)
        begin
            nearest = lsd_pkg::CMP_W'(fwd);
        end
    end

    assign res.shore = lsd_pkg::SHORE_W'(nearest);
    assign res.level = level;

endmodule

/* src/line_shore_distance_pass.sv */
// ----------------------------------------------------------------------------
// line_shore_distance_pass
// One capped 1-D distance transform pass over one line of a height map.
// ----------------------------------------------------------------------------
// Takes one height sample per cycle unless held off; returns one updated shore
// distance per position, in line order. A sample is land when height_sample
// is at or above water_threshold (APB register at byte address 0). Results lag
// the samples by MAX_LEVEL positions: the first result of a line is emitted
// once the sample that fills the six-entry look-ahead window is taken, then
// one result per cycle follows with one sample per cycle in while neither side
// stalls. On the last_in_line sample the window drains one result per ready
// cycle, the last tagged line_done, and the sample channel is held off until
// the drain is done. The output register decouples the two sides: samples
// keep flowing while a result waits, until the window is full.
// ----------------------------------------------------------------------------
module line_shore_distance_pass (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lsd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lsd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lsd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // streams
    lsd_in_if.sink                             in_ch,
    lsd_out_if.source                          out_ch
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [lsd_pkg::HEIGHT_W-1:0] thresh_reg;
    logic                         thr_sel;

    assign pready  = 1'b1;
    assign thr_sel = (paddr[2] == lsd_pkg::REG_IDX_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (psel && penable && pwrite && thr_sel)
        begin
            thresh_reg <= pwdata[lsd_pkg::HEIGHT_W-1:0];
        end
    end

    assign prdata = thr_sel ? lsd_pkg::APB_DATA_W'(thresh_reg) : '0;

    // ------------------------------------------------------------------
    // Window of pending positions, oldest at index 0
    // ------------------------------------------------------------------
    logic [lsd_pkg::WIN-1:0]                   land_reg,  land_next;
    logic [lsd_pkg::WIN-1:0][lsd_pkg::PRIOR_W-1:0] prior_reg, prior_next;
    logic [lsd_pkg::FILL_W-1:0]                fill_reg,  fill_next;
    logic [lsd_pkg::DIST_W-1:0]                back_reg,  back_next;
    lsd_pkg::state_t                           state_reg, state_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [lsd_pkg::SHORE_W-1:0] shore_reg,     shore_next;
    logic                        done_reg,      done_next;

    lsd_pkg::window_t win;
    lsd_pkg::emit_t   res;

    logic out_free;
    logic emit;
    logic last_emit;
    logic in_ready;
    logic accept;
    logic [lsd_pkg::FILL_W-1:0] fill_shift;
    logic [lsd_pkg::IDX_W-1:0]  ins_idx;

    assign win.land  = land_reg;
    assign win.prior = prior_reg;
    assign win.fill  = fill_reg;
    assign win.back  = back_reg;

    lsd_emit u_emit (
        .win (win),
        .res (res)
    );

    // If out_free, emit the oldest when the window is full or draining.
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign emit      = out_free && ((fill_reg == lsd_pkg::FILL_W'(lsd_pkg::WIN))
                                    || (state_reg == lsd_pkg::ST_FLUSH));
    assign last_emit = emit && (state_reg == lsd_pkg::ST_FLUSH)
                       && (fill_reg == lsd_pkg::FILL_W'(1));

    // In ST_STREAM a sample fits if a slot is free or one empties this cycle.
    assign in_ready = (state_reg == lsd_pkg::ST_STREAM)
                      && ((fill_reg < lsd_pkg::FILL_W'(lsd_pkg::WIN)) || emit);
    assign accept   = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    assign fill_shift = emit ? (fill_reg - 1'b1) : fill_reg;
    assign ins_idx    = fill_shift[lsd_pkg::IDX_W-1:0];

    always_comb
    begin
        land_next  = land_reg;
        prior_next = prior_reg;
        fill_next  = fill_shift;
        back_next  = back_reg;
        state_next = state_reg;

        if (emit)
        begin
            land_next  = land_reg >> 1;
            prior_next = prior_reg >> lsd_pkg::PRIOR_W;
            back_next  = last_emit ? lsd_pkg::DIST_W'(lsd_pkg::MAX_LEVEL) : res.level;
            if (last_emit)
            begin
                state_next = lsd_pkg::ST_STREAM;
            end
        end

        if (accept)
        begin
            for (int k = 0; k < lsd_pkg::WIN; k++)
            begin
                if (lsd_pkg::IDX_W'(k) == ins_idx)
                begin
                    land_next[k]  = (in_ch.height_sample >= thresh_reg);
                    prior_next[k] = in_ch.prior_distance;
                end
            end
            fill_next = fill_shift + 1'b1;
            if (in_ch.last_in_line)
            begin
                state_next = lsd_pkg::ST_FLUSH;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        shore_next     = shore_reg;
        done_next      = done_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            shore_next     = res.shore;
            done_next      = last_emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            back_reg      <= lsd_pkg::DIST_W'(lsd_pkg::MAX_LEVEL);
            state_reg     <= lsd_pkg::ST_STREAM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            back_reg      <= back_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed: entries beyond fill are never looked at
    always_ff @(posedge clk)
    begin
        land_reg  <= land_next;
        prior_reg <= prior_next;
        shore_reg <= shore_next;
        done_reg  <= done_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.shore_distance = shore_reg;
    assign out_ch.line_done      = done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= lsd_pkg::FILL_W'(lsd_pkg::WIN))
        else $error("window fill above depth");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsd_pkg::ST_FLUSH) |-> (fill_reg != '0) && !in_ch.ready)
        else $error("drain with empty window or sample taken during drain");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        last_emit |=> (fill_reg == '0) && (state_reg == lsd_pkg::ST_STREAM)
                      && (back_reg == lsd_pkg::DIST_W'(lsd_pkg::MAX_LEVEL)))
        else $error("window not reset after line end");

    a_dist_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.shore_distance <= lsd_pkg::SHORE_W'(lsd_pkg::MAX_LEVEL)))
        else $error("shore distance above cap");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the capped shore distance pass over height lines.
// ----------------------------------------------------------------------------
// Lines of height samples go in over the sample channel. Each accepted
// sample is run through a local model of the look-ahead window, and the
// distances it releases are queued. Every result transfer is checked against
// the oldest queued distance. The threshold register is rewritten only
// between lines, with the block drained. Sender gaps and receiver stalls come
// in three mixes: sparse sender with a busy receiver, the reverse, and none.
// ----------------------------------------------------------------------------
module testbench;

    // Register map: one register per word.
    localparam int THRESHOLD_REG = lsd_pkg::REG_IDX_THRESHOLD;
    localparam int SPARE_REG     = 1;        // unmapped, writes must not land

    // The block drains at most a window per line end; this covers it.
    localparam int DRAIN_SETTLE  = 16;
    // Quiet cycles (no transfer, no APB access) before the run is given up.
    localparam int QUIET_LIMIT   = 5000;

    typedef struct packed {
        logic [lsd_pkg::SHORE_W-1:0] shore;
        logic                        done;
    } shore_result_t;

    logic clk;
    logic rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lsd_pkg::APB_ADDR_W-1:0] paddr;
    logic [lsd_pkg::APB_DATA_W-1:0] pwdata;
    logic [lsd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    lsd_in_if  in_ch();
    lsd_out_if out_ch();

    line_shore_distance_pass dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Idle mix in percent per cycle.
    int sample_gap_pct;
    int result_stall_pct;

    int error_count;
    int quiet_cycles;

    // ------------------------------------------------------------------------
    // Local model of the window. Land is decided when the sample is taken,
    // using the threshold in force at that moment.
    // ------------------------------------------------------------------------
    logic [lsd_pkg::HEIGHT_W-1:0] land_threshold;
    logic                         land_flags [lsd_pkg::WIN];
    logic [lsd_pkg::PRIOR_W-1:0]  held_prior [lsd_pkg::WIN];
    int                           fill_count;
    int                           back_dist;

    shore_result_t                pending_shores [$];

    // Release window position i: min of held prior, nearest land behind
    // (carried in back_dist) and nearest land ahead, or line end if flushing.
    function automatic void release_position(int i, bit flushing, bit is_last);
        int            level;
        int            fwd;
        int            nearest;
        bit            found;
        shore_result_t res;
        level = land_flags[i] ? 0
              : ((back_dist + 1 > lsd_pkg::MAX_LEVEL) ? lsd_pkg::MAX_LEVEL
                                                      : back_dist + 1);
        back_dist = level;
        fwd = lsd_pkg::MAX_LEVEL + 1;
        found = 1'b0;
        for (int j = i + 1; j < fill_count && j < lsd_pkg::WIN; j++)
        begin
            if (!found && land_flags[j])
            begin
                fwd = j - i;
                found = 1'b1;
            end
        end
        // no land left in a flushed line: distance to one past its end
        if (!found && flushing)
            fwd = fill_count - i;
        if (fwd > lsd_pkg::MAX_LEVEL + 1)
            fwd = lsd_pkg::MAX_LEVEL + 1;
        nearest = held_prior[i];
        if (level < nearest)
            nearest = level;
        if (fwd < nearest)
            nearest = fwd;
        res.shore = lsd_pkg::SHORE_W'(nearest);
        res.done  = is_last;
        pending_shores = {pending_shores, res};
    endfunction

    function automatic void predict_shore_distances(logic [lsd_pkg::HEIGHT_W-1:0] height,
                                                    logic [lsd_pkg::PRIOR_W-1:0] prior,
                                                    logic last);
        if (fill_count < lsd_pkg::WIN)
        begin
            land_flags[fill_count] = (height >= land_threshold);
            held_prior[fill_count] = prior;
            fill_count++;
        end
        if (last)
        begin
            // line end: flush everything pending, then start over
            for (int i = 0; i < fill_count && i < lsd_pkg::WIN; i++)
                release_position(i, 1'b1, (i + 1 == fill_count));
            for (int i = 0; i < lsd_pkg::WIN; i++)
            begin
                land_flags[i] = 1'b0;
                held_prior[i] = '0;
            end
            fill_count = 0;
            back_dist = lsd_pkg::MAX_LEVEL;
        end
        else if (fill_count >= lsd_pkg::WIN)
        begin
            release_position(0, 1'b0, 1'b0);
            for (int i = 0; i < lsd_pkg::WIN - 1; i++)
            begin
                land_flags[i] = land_flags[i + 1];
                held_prior[i] = held_prior[i + 1];
            end
            land_flags[lsd_pkg::WIN - 1] = 1'b0;
            held_prior[lsd_pkg::WIN - 1] = '0;
            fill_count = lsd_pkg::WIN - 1;
        end
    endfunction

    function automatic void predict_register_write(int idx,
                                                   logic [lsd_pkg::APB_DATA_W-1:0] value);
        if (idx == THRESHOLD_REG)
            land_threshold = value[lsd_pkg::HEIGHT_W-1:0];
    endfunction

    task automatic note_failure(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Clock, watchdog, result checker
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Each result transfer is matched against the oldest queued distance;
    // ready is re-rolled every cycle for receiver stalls.
    always @(posedge clk)
    begin
        shore_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_shores.size() == 0)
            begin
                note_failure($sformatf("unexpected result: shore %0d done %0b",
                                       out_ch.shore_distance, out_ch.line_done));
            end
            else
            begin
                want = pending_shores.pop_front();
                if (out_ch.shore_distance !== want.shore)
                    note_failure($sformatf("shore_distance mismatch: expected %0d, got %0d",
                                           want.shore, out_ch.shore_distance));
                if (out_ch.line_done !== want.done)
                    note_failure($sformatf("line_done mismatch: expected %0b, got %0b",
                                           want.done, out_ch.line_done));
            end
        end
        out_ch.ready <= ($urandom_range(99) >= result_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends in the time step of a rising edge.
    // ------------------------------------------------------------------------

    // One transfer on the sample channel. valid stays high into the next call
    // when no gap is drawn, so back-to-back transfers get no bubble.
    task automatic send_sample(logic [lsd_pkg::HEIGHT_W-1:0] height,
                               logic [lsd_pkg::PRIOR_W-1:0] prior,
                               logic last);
        if ($urandom_range(99) < sample_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sample_gap_pct);
        end
        in_ch.valid          <= 1'b1;
        in_ch.height_sample  <= height;
        in_ch.prior_distance <= prior;
        in_ch.last_in_line   <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_shore_distances(height, prior, last);
    endtask

    // Park the sample channel and wait until every queued distance is out,
    // plus a DRAIN_SETTLE wait for anything still settling inside.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_shores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic write_register(int idx, logic [lsd_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsd_pkg::APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        predict_register_write(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Height that is land with roughly land_pct chance under threshold thr,
    // with some fully random, extreme and at-threshold values mixed in.
    function automatic logic [lsd_pkg::HEIGHT_W-1:0] pick_height(
        logic [lsd_pkg::HEIGHT_W-1:0] thr, int land_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return lsd_pkg::HEIGHT_W'($urandom_range(65535));
        if (r < 15)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if (r < 20)
            return (thr != 0 && $urandom_range(1)) ? thr - 1'b1 : thr;
        if (thr == 0 || $urandom_range(99) < land_pct)
            return lsd_pkg::HEIGHT_W'($urandom_range(65535, thr));
        return lsd_pkg::HEIGHT_W'($urandom_range(thr - 1'b1, 0));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Threshold left at reset value zero: everything is land, all zeros out,
    // even with priors of six and seven.
    task automatic test_all_land();
        send_sample(16'h0000, 3'd7, 1'b0);
        send_sample(16'hFFFF, 3'd6, 1'b0);
        send_sample(16'h1234, 3'd0, 1'b0);
        send_sample(16'h0000, 3'd5, 1'b1);
    endtask

    // Upper bits of a wide write are dropped; a write to the spare word must
    // leave the threshold alone (0x7FFF stays water).
    task automatic test_register_map();
        wait_drained();
        write_register(THRESHOLD_REG, 32'hABCD_8000);
        write_register(SPARE_REG, 32'h0000_0001);
        send_sample(16'h7FFF, 3'd5, 1'b0);
        send_sample(16'h8000, 3'd5, 1'b1);
    endtask

    // Lines no longer than the window flush whole at their last sample.
    task automatic test_short_lines();
        send_sample(16'h0000, 3'd5, 1'b1);
        for (int k = 0; k < lsd_pkg::WIN; k++)
            send_sample(16'h0001, 3'd5, k == lsd_pkg::WIN - 1);
    endtask

    // Longer than the window, land at both ends of a water run, odd priors.
    task automatic test_long_line();
        logic [lsd_pkg::HEIGHT_W-1:0] h;
        logic [lsd_pkg::PRIOR_W-1:0]  p;
        for (int k = 0; k < 12; k++)
        begin
            h = (k == 2 || k == 10) ? 16'hFFFF : 16'h0000;
            p = (k == 4) ? 3'd3 : (k == 6) ? 3'd7 : (k == 8) ? 3'd0 : 3'd5;
            send_sample(h, p, k == 11);
        end
    endtask

    // Random lines with threshold rewrites between blocks of lines.
    task automatic test_random_lines(int gap_pct, int stall_pct, int n_samples);
        int                           sent;
        int                           block_sent;
        int                           setting;
        int                           len;
        int                           land_pct;
        logic [lsd_pkg::HEIGHT_W-1:0] thr;
        logic [lsd_pkg::PRIOR_W-1:0]  p;
        sample_gap_pct   = gap_pct;
        result_stall_pct = stall_pct;
        sent = 0;
        setting = $urandom_range(3);
        while (sent < n_samples)
        begin
            // threshold changes only with the block idle
            wait_drained();
            case (setting % 4)
                0: thr = 16'hFFFF;
                1: thr = 16'h0000;
                default: thr = lsd_pkg::HEIGHT_W'($urandom_range(65535));
            endcase
            setting++;
            write_register(THRESHOLD_REG,
                           {lsd_pkg::HEIGHT_W'($urandom_range(65535)), thr});
            if ($urandom_range(3) == 0)
                write_register(SPARE_REG, $urandom);
            block_sent = 0;
            while (block_sent < 45 && sent < n_samples)
            begin
                len = ($urandom_range(99) < 10) ? $urandom_range(40, 15)
                                                : $urandom_range(14, 1);
                land_pct = $urandom_range(50, 5);
                for (int k = 0; k < len; k++)
                begin
                    p = ($urandom_range(99) < 60) ? lsd_pkg::PRIOR_W'(lsd_pkg::MAX_LEVEL)
                                                  : lsd_pkg::PRIOR_W'($urandom_range(7));
                    send_sample(pick_height(land_threshold, land_pct), p, k == len - 1);
                end
                block_sent += len;
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.height_sample  <= '0;
        in_ch.prior_distance <= '0;
        in_ch.last_in_line   <= 1'b0;
        error_count          = 0;
        quiet_cycles         = 0;
        land_threshold       = '0;
        fill_count           = 0;
        back_dist            = lsd_pkg::MAX_LEVEL;
        for (int i = 0; i < lsd_pkg::WIN; i++)
        begin
            land_flags[i] = 1'b0;
            held_prior[i] = '0;
        end
        sample_gap_pct   = 17;
        result_stall_pct = 68;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_all_land();
        test_register_map();
        test_short_lines();
        test_long_line();

        test_random_lines(17, 68, 118);
        test_random_lines(68, 17, 118);
        test_random_lines(0, 0, 119);

        wait_drained();
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
